// File: src/icr_pkg.sv
package icr_pkg;

   // Geometry and code width
   localparam int MAX_ROW_LENGTH = 1024;
   localparam int CODE_BITS      = 8;
   localparam int COL_BITS       = $clog2(MAX_ROW_LENGTH);
   localparam int LEN_BITS       = COL_BITS + 1;
   localparam int ROW_BITS       = 16;
   localparam int ROW_CNT_BITS   = ROW_BITS + 1;
   localparam int WIN_BITS       = 9;

   // Register file
   localparam int REG_COUNT     = 4;
   localparam int REG_IDX_BITS  = $clog2(REG_COUNT);
   localparam int ADDR_BITS     = REG_IDX_BITS + 2;
   localparam int DATA_BITS     = 32;

   localparam logic [REG_IDX_BITS-1:0] REG_ROW_LENGTH    = 2'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_ROW_COUNT     = 2'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_OCCUPIED_CODE = 2'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_CLEARED_CODE  = 2'd3;

   localparam logic [LEN_BITS-1:0]  ROW_LENGTH_RESET    = LEN_BITS'(1024);
   localparam logic [ROW_BITS-1:0]  ROW_COUNT_RESET     = ROW_BITS'(1024);
   localparam logic [CODE_BITS-1:0] OCCUPIED_CODE_RESET = CODE_BITS'(100);
   localparam logic [CODE_BITS-1:0] CLEARED_CODE_RESET  = CODE_BITS'(0);

   // Window bits that are neighbors of the center cell (all but the center)
   localparam logic [WIN_BITS-1:0] NEIGHBOR_MASK = 9'h1EF;

   typedef struct packed {
      logic [LEN_BITS-1:0]  row_length;
      logic [ROW_BITS-1:0]  row_count;
      logic [CODE_BITS-1:0] occupied_code;
      logic [CODE_BITS-1:0] cleared_code;
   } cfg_type;

   // Item held between the line stores and the window stage
   typedef struct packed {
      logic                 valid;
      logic                 drop;      // pad item inside the frame
      logic                 clr;       // frame restarts before this item
      logic                 emit;      // item yields a result
      logic                 last;      // result closes the frame
      logic                 ic_zero;   // item sits in the first column
      logic                 up_ok;     // upper row lies inside the grid
      logic                 lo_ok;     // lower row lies inside the grid
      logic                 code_occ;  // entering cell is occupied
      logic [CODE_BITS-1:0] up;
      logic [CODE_BITS-1:0] lo;
   } win_item_type;

endpackage

// File: src/icr_if.sv
interface icr_req_if import icr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CODE_BITS-1:0] cell_code;
   logic                 pad;

   modport source (output valid, cell_code, pad, input ready);
   modport sink   (input valid, cell_code, pad, output ready);
endinterface

interface icr_rsp_if import icr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CODE_BITS-1:0] filtered_code;
   logic                 frame_last;

   modport source (output valid, filtered_code, frame_last, input ready);
   modport sink   (input valid, filtered_code, frame_last, output ready);
endinterface

// File: src/icr_csr.sv
module icr_csr import icr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready,
   output cfg_type              cfg
);

   cfg_type                 cfg_ff;
   logic                    wr_en;
   logic [REG_IDX_BITS-1:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[ADDR_BITS-1:2];
   assign cfg    = cfg_ff;

   // Register writes on the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_length    <= ROW_LENGTH_RESET;
         cfg_ff.row_count     <= ROW_COUNT_RESET;
         cfg_ff.occupied_code <= OCCUPIED_CODE_RESET;
         cfg_ff.cleared_code  <= CLEARED_CODE_RESET;
      end else if (wr_en) begin
         unique case (idx)
            REG_ROW_LENGTH:    cfg_ff.row_length    <= pwdata[LEN_BITS-1:0];
            REG_ROW_COUNT:     cfg_ff.row_count     <= pwdata[ROW_BITS-1:0];
            REG_OCCUPIED_CODE: cfg_ff.occupied_code <= pwdata[CODE_BITS-1:0];
            REG_CLEARED_CODE:  cfg_ff.cleared_code  <= pwdata[CODE_BITS-1:0];
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (idx)
         REG_ROW_LENGTH:    prdata = DATA_BITS'(cfg_ff.row_length);
         REG_ROW_COUNT:     prdata = DATA_BITS'(cfg_ff.row_count);
         REG_OCCUPIED_CODE: prdata = DATA_BITS'(cfg_ff.occupied_code);
         REG_CLEARED_CODE:  prdata = DATA_BITS'(cfg_ff.cleared_code);
      endcase
   end

endmodule

// File: src/icr_scan.sv
module icr_scan import icr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   icr_req_if.sink      req,
   input  cfg_type      cfg,
   input  logic         out_free,
   output win_item_type item,
   output logic         item_adv
);

   logic [COL_BITS-1:0]     col_ff, col_in;
   logic [ROW_CNT_BITS-1:0] row_ff, row_in;

   logic [CODE_BITS-1:0] lower_mem [MAX_ROW_LENGTH];
   logic [CODE_BITS-1:0] upper_mem [MAX_ROW_LENGTH];
   logic [CODE_BITS-1:0] lower_rd_ff;
   logic [CODE_BITS-1:0] upper_rd_ff;
   logic                 fwd_ff;
   logic [CODE_BITS-1:0] fwd_data_ff;

   logic                s1_valid_ff;
   logic                s1_drop_ff, s1_clr_ff, s1_emit_ff, s1_last_ff;
   logic                s1_ic_zero_ff, s1_up_ok_ff, s1_lo_ok_ff, s1_code_occ_ff;
   logic [COL_BITS-1:0] s1_col_ff;

   logic [LEN_BITS-1:0]     w_eff;
   logic [ROW_CNT_BITS-1:0] h_ext, h_p1;
   logic                    restart;
   logic [ROW_CNT_BITS-1:0] ir, ir_inc;
   logic [COL_BITS-1:0]     ic;
   logic [LEN_BITS-1:0]     ic_inc;
   logic                    ir_lt_h, drop, ic_zero, up_ok, lo_ok, emit_raw, last_raw;
   logic                    code_occ, accept, wr_upper;

   // Effective grid size
   always_comb begin
      if (cfg.row_length == '0)
         w_eff = LEN_BITS'(1);
      else if (cfg.row_length > LEN_BITS'(MAX_ROW_LENGTH))
         w_eff = LEN_BITS'(MAX_ROW_LENGTH);
      else
         w_eff = cfg.row_length;
      h_ext = (cfg.row_count == '0) ? ROW_CNT_BITS'(1) : {1'b0, cfg.row_count};
      h_p1  = h_ext + ROW_CNT_BITS'(1);
   end

   // Position of the entering item and what it yields
   always_comb begin
      restart  = (row_ff > h_p1) || (row_ff == h_p1 && col_ff != '0);
      ir       = restart ? '0 : row_ff;
      ic       = restart ? '0 : col_ff;
      ir_inc   = ir + ROW_CNT_BITS'(1);
      ic_inc   = {1'b0, ic} + LEN_BITS'(1);
      ir_lt_h  = ir < h_ext;
      drop     = ir_lt_h && req.pad;
      ic_zero  = ic == '0;
      up_ok    = ir >= ROW_CNT_BITS'(2);
      lo_ok    = ir != '0 && ir <= h_ext;
      emit_raw = ic_zero ? (up_ok && ir <= h_p1) : lo_ok;
      last_raw = ic_zero ? (ir == h_p1) : (ir == h_ext && {1'b0, ic} == w_eff);
      code_occ = ir_lt_h && req.cell_code == cfg.occupied_code;
   end

   assign item_adv  = s1_valid_ff && (!s1_emit_ff || out_free);
   assign req.ready = !s1_valid_ff || item_adv;
   assign accept    = req.valid && req.ready;
   assign wr_upper  = item_adv && !s1_drop_ff;

   // Advance the raster position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (drop) begin
            col_in = ic;
            row_in = ir;
         end else if (last_raw) begin
            col_in = '0;
            row_in = '0;
         end else if (ic_inc >= w_eff) begin
            col_in = '0;
            row_in = ir_inc;
         end else begin
            col_in = ic_inc[COL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= wr_upper && s1_col_ff == ic;
         end else if (item_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the item flags for the window stage
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_drop_ff     <= drop;
         s1_clr_ff      <= restart;
         s1_emit_ff     <= !drop && emit_raw;
         s1_last_ff     <= !drop && last_raw;
         s1_ic_zero_ff  <= ic_zero;
         s1_up_ok_ff    <= up_ok;
         s1_lo_ok_ff    <= lo_ok;
         s1_code_occ_ff <= code_occ;
         s1_col_ff      <= ic;
         fwd_data_ff    <= lower_rd_ff;
      end
   end

   // Lower line store: read old entry, write entering code (zero past the last row)
   always_ff @(posedge clock) begin
      if (accept) begin
         lower_rd_ff <= lower_mem[ic];
         if (!drop)
            lower_mem[ic] <= ir_lt_h ? req.cell_code : '0;
      end
   end

   // Upper line store: takes the lower row entry once the item leaves
   always_ff @(posedge clock) begin
      if (accept)
         upper_rd_ff <= upper_mem[ic];
      if (wr_upper)
         upper_mem[s1_col_ff] <= lower_rd_ff;
   end

   always_comb begin
      item.valid    = s1_valid_ff;
      item.drop     = s1_drop_ff;
      item.clr      = s1_clr_ff;
      item.emit     = s1_emit_ff;
      item.last     = s1_last_ff;
      item.ic_zero  = s1_ic_zero_ff;
      item.up_ok    = s1_up_ok_ff;
      item.lo_ok    = s1_lo_ok_ff;
      item.code_occ = s1_code_occ_ff;
      item.up       = fwd_ff ? fwd_data_ff : upper_rd_ff;
      item.lo       = lower_rd_ff;
   end

   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_drop_ff) |-> (!s1_emit_ff && !s1_last_ff))
      else $error("pad item inside the frame marked as yielding a result");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !item_adv) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("stalled item left the window stage input");

endmodule

// File: src/icr_window.sv
module icr_window import icr_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  win_item_type item,
   input  logic         item_adv,
   output logic         out_free,
   icr_rsp_if.source    rsp
);

   logic [WIN_BITS-1:0]  window_ff, window_in;
   logic [CODE_BITS-1:0] center_ff, center_in;
   logic                 out_valid_ff;
   logic [CODE_BITS-1:0] out_code_ff;
   logic                 out_last_ff;

   logic [WIN_BITS-1:0]  win_base, win_shift, win_cur;
   logic [CODE_BITS-1:0] cc_base, filt;
   logic [2:0]           col;
   logic                 isolated;

   // Shift the entering column into the window and test the center
   always_comb begin
      win_base  = item.clr ? '0 : window_ff;
      cc_base   = item.clr ? '0 : center_ff;
      col       = {item.code_occ,
                   item.lo_ok && item.lo == cfg.occupied_code,
                   item.up_ok && item.up == cfg.occupied_code};
      win_shift = {3'b000, win_base[WIN_BITS-1:3]};
      win_cur   = item.ic_zero ? win_shift : (win_shift | {col, 6'b000000});
      isolated  = cc_base == cfg.occupied_code && (win_cur & NEIGHBOR_MASK) == '0;
      filt      = isolated ? cfg.cleared_code : cc_base;
   end

   always_comb begin
      window_in = window_ff;
      center_in = center_ff;
      if (item_adv) begin
         if (item.drop) begin
            window_in = win_base;
            center_in = cc_base;
         end else if (item.last) begin
            window_in = '0;
            center_in = '0;
         end else begin
            window_in = item.ic_zero ? {col, 6'b000000} : win_cur;
            center_in = item.lo;
         end
      end
   end

   assign out_free = !out_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= '0;
         center_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         center_ff <= center_in;
         if (item_adv && item.emit)
            out_valid_ff <= 1'b1;
         else if (rsp.ready)
            out_valid_ff <= 1'b0;
      end
   end

   // Load the result register
   always_ff @(posedge clock) begin
      if (item_adv && item.emit) begin
         out_code_ff <= filt;
         out_last_ff <= item.last;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.filtered_code = out_code_ff;
   assign rsp.frame_last    = out_last_ff;

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (item_adv && item.last) |=> (window_ff == '0 && center_ff == '0))
      else $error("window not cleared after the last cell of the frame");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (item_adv && item.emit) |=> out_valid_ff)
      else $error("result lost on its way to the output register");

endmodule

// File: src/isolated_cell_removal_3x3_core.sv
// Result order: the result for a cell leaves row_length + 1 accepted items after the cell,
//   passing through the line-store read register, then the output register.
// Throughput: one item per cycle; while a result waits on the output, items that yield
//   no result still pass, and the first one that yields a result holds the input.
// Reset (synchronous, active high) clears position counters, window and valid flags;
//   the two line stores are not cleared and need no clearing pass.
module isolated_cell_removal_3x3_core import icr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   icr_req_if.sink              req_ch,
   icr_rsp_if.source            rsp_ch,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [ADDR_BITS-1:0] paddr,
   input  logic [DATA_BITS-1:0] pwdata,
   output logic [DATA_BITS-1:0] prdata,
   output logic                 pready
);

   cfg_type      cfg;
   win_item_type item;
   logic         item_adv;
   logic         out_free;

   icr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   icr_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .req      (req_ch),
      .cfg      (cfg),
      .out_free (out_free),
      .item     (item),
      .item_adv (item_adv)
   );

   icr_window u_window (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .item     (item),
      .item_adv (item_adv),
      .out_free (out_free),
      .rsp      (rsp_ch)
   );

endmodule
